>>> rtl/core/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and constants of the punctuator tokenizer
// Scan modes, token kinds, punctuator indices and the result pair type.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int unsigned MODE_W = 5;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // scan modes
  localparam logic [MODE_W-1:0] M_IDLE   = 5'd0;
  localparam logic [MODE_W-1:0] M_LINE   = 5'd1;
  localparam logic [MODE_W-1:0] M_BLOCK  = 5'd2;
  localparam logic [MODE_W-1:0] M_BSTAR  = 5'd3;
  localparam logic [MODE_W-1:0] M_SLASH  = 5'd4;
  localparam logic [MODE_W-1:0] M_MINUS  = 5'd5;
  localparam logic [MODE_W-1:0] M_PLUS   = 5'd6;
  localparam logic [MODE_W-1:0] M_LT     = 5'd7;
  localparam logic [MODE_W-1:0] M_LTLT   = 5'd8;
  localparam logic [MODE_W-1:0] M_GT     = 5'd9;
  localparam logic [MODE_W-1:0] M_GTGT   = 5'd10;
  localparam logic [MODE_W-1:0] M_EQ     = 5'd11;
  localparam logic [MODE_W-1:0] M_BANG   = 5'd12;
  localparam logic [MODE_W-1:0] M_AMP    = 5'd13;
  localparam logic [MODE_W-1:0] M_PIPE   = 5'd14;
  localparam logic [MODE_W-1:0] M_DOT    = 5'd15;
  localparam logic [MODE_W-1:0] M_DOTDOT = 5'd16;
  localparam logic [MODE_W-1:0] M_STAR   = 5'd17;
  localparam logic [MODE_W-1:0] M_PCT    = 5'd18;
  localparam logic [MODE_W-1:0] M_PCTC   = 5'd19;
  localparam logic [MODE_W-1:0] M_PCTCP  = 5'd20;
  localparam logic [MODE_W-1:0] M_HASH   = 5'd21;
  localparam logic [MODE_W-1:0] M_CARET  = 5'd22;

  // token kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_PUNCT = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  // punctuator indices
  localparam logic [7:0] P_ARROW     = 8'd0;
  localparam logic [7:0] P_DEC       = 8'd1;
  localparam logic [7:0] P_SUB_EQ    = 8'd2;
  localparam logic [7:0] P_INC       = 8'd3;
  localparam logic [7:0] P_ADD_EQ    = 8'd4;
  localparam logic [7:0] P_SHL       = 8'd5;
  localparam logic [7:0] P_SHL_EQ    = 8'd6;
  localparam logic [7:0] P_LE        = 8'd7;
  localparam logic [7:0] P_LT_COLON  = 8'd8;
  localparam logic [7:0] P_LT_PCT    = 8'd9;
  localparam logic [7:0] P_SHR       = 8'd10;
  localparam logic [7:0] P_SHR_EQ    = 8'd11;
  localparam logic [7:0] P_GE        = 8'd12;
  localparam logic [7:0] P_EQ_EQ     = 8'd13;
  localparam logic [7:0] P_NE        = 8'd14;
  localparam logic [7:0] P_LAND      = 8'd15;
  localparam logic [7:0] P_AND_EQ    = 8'd16;
  localparam logic [7:0] P_LOR       = 8'd17;
  localparam logic [7:0] P_OR_EQ     = 8'd18;
  localparam logic [7:0] P_ELLIPSIS  = 8'd19;
  localparam logic [7:0] P_MUL_EQ    = 8'd20;
  localparam logic [7:0] P_DIV_EQ    = 8'd21;
  localparam logic [7:0] P_MOD_EQ    = 8'd22;
  localparam logic [7:0] P_PCT_GT    = 8'd23;
  localparam logic [7:0] P_PCT_COLON = 8'd24;
  localparam logic [7:0] P_DPASTE    = 8'd25;
  localparam logic [7:0] P_HASHHASH  = 8'd26;
  localparam logic [7:0] P_XOR_EQ    = 8'd27;

  // characters
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // one or two results caused by one request
  typedef struct packed {
    logic       two;
    logic [1:0] kind0;
    logic [7:0] code0;
    logic [1:0] kind1;
    logic [7:0] code1;
  } tok_pair_t;

  typedef struct packed {
    logic      nonempty;
    tok_pair_t head;
  } q_head_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  // mode entered from idle by a lead byte, idle for anything else
  function automatic logic [MODE_W-1:0] start_mode(input logic [7:0] c);
    logic [MODE_W-1:0] m;
    unique case (c)
      CH_SLASH: m = M_SLASH;
      CH_MINUS: m = M_MINUS;
      CH_PLUS:  m = M_PLUS;
      CH_LT:    m = M_LT;
      CH_GT:    m = M_GT;
      CH_EQ:    m = M_EQ;
      CH_BANG:  m = M_BANG;
      CH_AMP:   m = M_AMP;
      CH_PIPE:  m = M_PIPE;
      CH_DOT:   m = M_DOT;
      CH_STAR:  m = M_STAR;
      CH_PCT:   m = M_PCT;
      CH_HASH:  m = M_HASH;
      CH_CARET: m = M_CARET;
      default:  m = M_IDLE;
    endcase
    return m;
  endfunction

  // byte that opened a single-byte pending prefix, zero otherwise
  function automatic logic [7:0] lead_of(input logic [MODE_W-1:0] m);
    logic [7:0] c;
    unique case (m)
      M_SLASH: c = CH_SLASH;
      M_MINUS: c = CH_MINUS;
      M_PLUS:  c = CH_PLUS;
      M_LT:    c = CH_LT;
      M_GT:    c = CH_GT;
      M_EQ:    c = CH_EQ;
      M_BANG:  c = CH_BANG;
      M_AMP:   c = CH_AMP;
      M_PIPE:  c = CH_PIPE;
      M_DOT:   c = CH_DOT;
      M_STAR:  c = CH_STAR;
      M_PCT:   c = CH_PCT;
      M_HASH:  c = CH_HASH;
      M_CARET: c = CH_CARET;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/c_punctuator_tokenizer.sv
// ----------------------------------------------------------------------------
// c_punctuator_tokenizer: C punctuator tokenizer, longest match with digraphs
// Drops whitespace and comments, emits punctuator, byte, error and end tokens.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one source byte per request, or an
// end marker (in_at_end) that flushes any pending prefix and yields an end
// token. Result channel (out_valid/out_ready): kind, code and a last flag on
// the final result of a request; a request yields zero, one or two results.
// The front end takes one request per cycle while the four-entry pair queue
// has room; the mode register update is the only loop. Results pass through
// the registered pair queue before they reach the output. Requests with one
// result sustain one result per cycle while out_ready is high; one with two
// results holds the output for both. A stalled receiver fills the queue,
// then in_ready drops; the scan state is unaffected. Reset returns the
// scanner to idle with no pending prefix and empties the queue.
// ----------------------------------------------------------------------------
module c_punctuator_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_req,
  input  logic       in_at_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_code,
  output logic       out_last
);
  import cpt_pkg::*;

  logic      q_full;
  logic      push;
  tok_pair_t push_data;
  logic      pop;
  q_head_t   head;

  cpt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte_req (in_byte_req),
    .in_at_end   (in_at_end),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  cpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .head      (head)
  );

  cpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_code  (out_code),
    .out_last  (out_last)
  );

endmodule

>>> rtl/core/cpt_front.sv
// ----------------------------------------------------------------------------
// cpt_front: scanner front end
// Holds the scan mode, classifies each request and forms its result pair.
// ----------------------------------------------------------------------------
module cpt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte_req,
  input  logic               in_at_end,
  input  logic               q_full,
  output logic               push,
  output cpt_pkg::tok_pair_t push_data
);
  import cpt_pkg::*;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              fl;      // a prefix or finished punctuator goes out first
  logic [1:0]        fk;
  logic [7:0]        fc;
  logic              st;      // byte is then handled from idle
  logic              se;      // that handling emits the byte itself
  logic              accept;
  logic [7:0]        c;

  assign c        = in_byte_req;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    fl       = 1'b0;
    fk       = KIND_BYTE;
    fc       = 8'd0;
    st       = 1'b0;
    mode_nxt = mode_r;
    if (in_at_end) begin
      mode_nxt = M_IDLE;
      if (mode_r == M_LTLT) begin
        fl = 1'b1; fk = KIND_PUNCT; fc = P_SHL;
      end else if (mode_r == M_GTGT) begin
        fl = 1'b1; fk = KIND_PUNCT; fc = P_SHR;
      end else if (mode_r == M_PCTC) begin
        fl = 1'b1; fk = KIND_PUNCT; fc = P_PCT_COLON;
      end else if (mode_r == M_DOTDOT || mode_r == M_PCTCP ||
                   mode_r == M_BLOCK || mode_r == M_BSTAR) begin
        fl = 1'b1; fk = KIND_ERR;
      end else if (lead_of(mode_r) != 8'd0) begin
        fl = 1'b1; fk = KIND_BYTE; fc = lead_of(mode_r);
      end
    end else begin
      unique case (mode_r)
        M_IDLE: st = 1'b1;
        M_LINE: if (c == CH_NL) mode_nxt = M_IDLE;
        M_BLOCK: if (c == CH_STAR) mode_nxt = M_BSTAR;
        M_BSTAR: begin
          if (c == CH_SLASH) mode_nxt = M_IDLE;
          else if (c == CH_STAR) mode_nxt = M_BSTAR;
          else mode_nxt = M_BLOCK;
        end
        M_LTLT: begin
          fl = 1'b1; fk = KIND_PUNCT;
          if (c == CH_EQ) begin
            fc = P_SHL_EQ; mode_nxt = M_IDLE;
          end else begin
            fc = P_SHL; st = 1'b1;
          end
        end
        M_GTGT: begin
          fl = 1'b1; fk = KIND_PUNCT;
          if (c == CH_EQ) begin
            fc = P_SHR_EQ; mode_nxt = M_IDLE;
          end else begin
            fc = P_SHR; st = 1'b1;
          end
        end
        M_DOTDOT: begin
          fl = 1'b1;
          if (c == CH_DOT) begin
            fk = KIND_PUNCT; fc = P_ELLIPSIS; mode_nxt = M_IDLE;
          end else begin
            fk = KIND_ERR; st = 1'b1;
          end
        end
        M_PCTC: begin
          if (c == CH_PCT) begin
            mode_nxt = M_PCTCP;
          end else begin
            fl = 1'b1; fk = KIND_PUNCT; fc = P_PCT_COLON; st = 1'b1;
          end
        end
        M_PCTCP: begin
          fl = 1'b1;
          if (c == CH_COLON) begin
            fk = KIND_PUNCT; fc = P_DPASTE; mode_nxt = M_IDLE;
          end else begin
            fk = KIND_ERR; st = 1'b1;
          end
        end
        M_SLASH, M_MINUS, M_PLUS, M_LT, M_GT, M_EQ, M_BANG, M_AMP, M_PIPE,
        M_DOT, M_STAR, M_PCT, M_HASH, M_CARET: begin
          // single-byte prefix: completes, extends, or its lead byte goes out
          fl       = 1'b1;
          fk       = KIND_PUNCT;
          mode_nxt = M_IDLE;
          if (mode_r == M_SLASH && c == CH_SLASH) begin
            fl = 1'b0; mode_nxt = M_LINE;
          end else if (mode_r == M_SLASH && c == CH_STAR) begin
            fl = 1'b0; mode_nxt = M_BLOCK;
          end else if (mode_r == M_LT && c == CH_LT) begin
            fl = 1'b0; mode_nxt = M_LTLT;
          end else if (mode_r == M_GT && c == CH_GT) begin
            fl = 1'b0; mode_nxt = M_GTGT;
          end else if (mode_r == M_DOT && c == CH_DOT) begin
            fl = 1'b0; mode_nxt = M_DOTDOT;
          end else if (mode_r == M_PCT && c == CH_COLON) begin
            fl = 1'b0; mode_nxt = M_PCTC;
          end else if (mode_r == M_SLASH && c == CH_EQ) fc = P_DIV_EQ;
          else if (mode_r == M_MINUS && c == CH_GT) fc = P_ARROW;
          else if (mode_r == M_MINUS && c == CH_MINUS) fc = P_DEC;
          else if (mode_r == M_MINUS && c == CH_EQ) fc = P_SUB_EQ;
          else if (mode_r == M_PLUS && c == CH_PLUS) fc = P_INC;
          else if (mode_r == M_PLUS && c == CH_EQ) fc = P_ADD_EQ;
          else if (mode_r == M_LT && c == CH_EQ) fc = P_LE;
          else if (mode_r == M_LT && c == CH_COLON) fc = P_LT_COLON;
          else if (mode_r == M_LT && c == CH_PCT) fc = P_LT_PCT;
          else if (mode_r == M_GT && c == CH_EQ) fc = P_GE;
          else if (mode_r == M_EQ && c == CH_EQ) fc = P_EQ_EQ;
          else if (mode_r == M_BANG && c == CH_EQ) fc = P_NE;
          else if (mode_r == M_AMP && c == CH_AMP) fc = P_LAND;
          else if (mode_r == M_AMP && c == CH_EQ) fc = P_AND_EQ;
          else if (mode_r == M_PIPE && c == CH_PIPE) fc = P_LOR;
          else if (mode_r == M_PIPE && c == CH_EQ) fc = P_OR_EQ;
          else if (mode_r == M_STAR && c == CH_EQ) fc = P_MUL_EQ;
          else if (mode_r == M_PCT && c == CH_EQ) fc = P_MOD_EQ;
          else if (mode_r == M_PCT && c == CH_GT) fc = P_PCT_GT;
          else if (mode_r == M_HASH && c == CH_HASH) fc = P_HASHHASH;
          else if (mode_r == M_CARET && c == CH_EQ) fc = P_XOR_EQ;
          else begin
            fk = KIND_BYTE; fc = lead_of(mode_r); st = 1'b1;
          end
        end
        // unused mode codes recover to idle without a flush
        default: st = 1'b1;
      endcase
      if (st) mode_nxt = start_mode(c);
    end
  end

  assign se = st && !in_at_end && !is_space(c) && (start_mode(c) == M_IDLE);

  always_comb begin
    if (in_at_end) begin
      push_data.two   = fl;
      push_data.kind0 = fl ? fk : KIND_END;
      push_data.code0 = fl ? fc : 8'd0;
      push_data.kind1 = KIND_END;
      push_data.code1 = 8'd0;
      push            = accept;
    end else begin
      push_data.two   = fl && se;
      push_data.kind0 = fl ? fk : KIND_BYTE;
      push_data.code0 = fl ? fc : c;
      push_data.kind1 = KIND_BYTE;
      push_data.code1 = c;
      push            = accept && (fl || se);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

>>> rtl/core/cpt_queue.sv
// ----------------------------------------------------------------------------
// cpt_queue: result pair queue
// Short queue between the scanner front end and the result sequencer.
// ----------------------------------------------------------------------------
module cpt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cpt_pkg::tok_pair_t push_data,
  input  logic               pop,
  output logic               full,
  output cpt_pkg::q_head_t   head
);
  import cpt_pkg::*;

  tok_pair_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_pop;

  assign full          = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign head.nonempty = (cnt_r != '0);
  assign head.head     = mem[rptr_r];
  assign do_pop        = pop && head.nonempty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + QPTR_W'(1);
      if (do_pop) rptr_r <= rptr_r + QPTR_W'(1);
      if (push && !do_pop) cnt_r <= cnt_r + (QPTR_W+1)'(1);
      else if (!push && do_pop) cnt_r <= cnt_r - (QPTR_W+1)'(1);
    end
  end

endmodule

>>> rtl/core/cpt_back.sv
// ----------------------------------------------------------------------------
// cpt_back: result sequencer
// Sends the one or two results of the queue head, marking the last of them.
// ----------------------------------------------------------------------------
module cpt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  cpt_pkg::q_head_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_code,
  output logic             out_last
);
  import cpt_pkg::*;

  logic sel_r;   // second result of the head pair is up
  logic fire;

  assign out_valid = head.nonempty;
  assign out_kind  = sel_r ? head.head.kind1 : head.head.kind0;
  assign out_code  = sel_r ? head.head.code1 : head.head.code0;
  assign out_last  = sel_r || !head.head.two;
  assign fire      = out_valid && out_ready;
  assign pop       = fire && out_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (fire) begin
      sel_r <= !out_last;
    end
  end

endmodule

>>> test/c_punctuator_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// c_punctuator_tokenizer_tb: self-checking bench for the punctuator tokenizer
// A short table of directed byte streams, then random token text with broken
// prefixes, comments and end markers, is fed through the request channel.
// Each token is checked per field against typed rows or a local scanner model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module c_punctuator_tokenizer_tb;
  import cpt_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic       last;
  } tok_t;

  // one request; n_fixed >= 0 carries its tokens typed in, -1 means predicted
  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic       hold;
    int         n_fixed;
    tok_t       t0;
    tok_t       t1;
  } req_t;

  logic       clk;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte_req = 8'h00;
  logic       in_at_end   = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_code;
  logic       out_last;

  // tokens of the request currently on the input channel, when typed in
  int   cur_n_fixed = -1;
  tok_t cur_t0, cur_t1;

  tok_t pending_tokens[$];
  tok_t step_toks[$];
  req_t stim_q[$];
  int   n_errors  = 0;
  bit   quiet     = 0;

  // scanner model state
  logic [MODE_W-1:0] lex_mode = M_IDLE;
  logic [7:0]        lex_lead = 8'h00;

  string punct_text =
    "-> -- -= ++ += << <<= <= <: <% >> >>= >= == != && &= || |= ... *= /= %= %> %: %:%: ## ^=";
  string lead_text  = "/-+<>=!&|.*%#^";

  c_punctuator_tokenizer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte_req (in_byte_req),
    .in_at_end   (in_at_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_code    (out_code),
    .out_last    (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // ---------------- scanner model ----------------

  function automatic void put_tok(input logic [1:0] k, input logic [7:0] c);
    tok_t t;
    t.kind = k;
    t.code = c;
    t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void open_mode(input logic [7:0] c);
    lex_lead = c;
    case (c)
      CH_SP, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR: ;
      CH_SLASH: lex_mode = M_SLASH;
      CH_MINUS: lex_mode = M_MINUS;
      CH_PLUS:  lex_mode = M_PLUS;
      CH_LT:    lex_mode = M_LT;
      CH_GT:    lex_mode = M_GT;
      CH_EQ:    lex_mode = M_EQ;
      CH_BANG:  lex_mode = M_BANG;
      CH_AMP:   lex_mode = M_AMP;
      CH_PIPE:  lex_mode = M_PIPE;
      CH_DOT:   lex_mode = M_DOT;
      CH_STAR:  lex_mode = M_STAR;
      CH_PCT:   lex_mode = M_PCT;
      CH_HASH:  lex_mode = M_HASH;
      CH_CARET: lex_mode = M_CARET;
      default:  put_tok(KIND_BYTE, c);
    endcase
  endfunction

  function automatic void reopen(input logic [7:0] c);
    lex_mode = M_IDLE;
    open_mode(c);
  endfunction

  function automatic void take(input logic [7:0] idx);
    put_tok(KIND_PUNCT, idx);
    lex_mode = M_IDLE;
  endfunction

  function automatic void advance_mode(input logic [7:0] c);
    logic miss;
    miss = 1'b0;
    case (lex_mode)
      M_IDLE:  open_mode(c);
      M_LINE:  if (c == CH_NL) lex_mode = M_IDLE;
      M_BLOCK: if (c == CH_STAR) lex_mode = M_BSTAR;
      M_BSTAR: begin
        if (c == CH_SLASH) lex_mode = M_IDLE;
        else if (c != CH_STAR) lex_mode = M_BLOCK;
      end
      M_SLASH: begin
        if (c == CH_SLASH) lex_mode = M_LINE;
        else if (c == CH_STAR) lex_mode = M_BLOCK;
        else if (c == CH_EQ) take(P_DIV_EQ);
        else miss = 1'b1;
      end
      M_MINUS: begin
        if (c == CH_GT) take(P_ARROW);
        else if (c == CH_MINUS) take(P_DEC);
        else if (c == CH_EQ) take(P_SUB_EQ);
        else miss = 1'b1;
      end
      M_PLUS: begin
        if (c == CH_PLUS) take(P_INC);
        else if (c == CH_EQ) take(P_ADD_EQ);
        else miss = 1'b1;
      end
      M_LT: begin
        if (c == CH_LT) lex_mode = M_LTLT;
        else if (c == CH_EQ) take(P_LE);
        else if (c == CH_COLON) take(P_LT_COLON);
        else if (c == CH_PCT) take(P_LT_PCT);
        else miss = 1'b1;
      end
      M_LTLT: begin
        if (c == CH_EQ) take(P_SHL_EQ);
        else begin
          put_tok(KIND_PUNCT, P_SHL);
          reopen(c);
        end
      end
      M_GT: begin
        if (c == CH_GT) lex_mode = M_GTGT;
        else if (c == CH_EQ) take(P_GE);
        else miss = 1'b1;
      end
      M_GTGT: begin
        if (c == CH_EQ) take(P_SHR_EQ);
        else begin
          put_tok(KIND_PUNCT, P_SHR);
          reopen(c);
        end
      end
      M_EQ:   if (c == CH_EQ) take(P_EQ_EQ); else miss = 1'b1;
      M_BANG: if (c == CH_EQ) take(P_NE); else miss = 1'b1;
      M_AMP: begin
        if (c == CH_AMP) take(P_LAND);
        else if (c == CH_EQ) take(P_AND_EQ);
        else miss = 1'b1;
      end
      M_PIPE: begin
        if (c == CH_PIPE) take(P_LOR);
        else if (c == CH_EQ) take(P_OR_EQ);
        else miss = 1'b1;
      end
      M_DOT: if (c == CH_DOT) lex_mode = M_DOTDOT; else miss = 1'b1;
      M_DOTDOT: begin
        if (c == CH_DOT) take(P_ELLIPSIS);
        else begin
          put_tok(KIND_ERR, 8'h00);
          reopen(c);
        end
      end
      M_STAR: if (c == CH_EQ) take(P_MUL_EQ); else miss = 1'b1;
      M_PCT: begin
        if (c == CH_COLON) lex_mode = M_PCTC;
        else if (c == CH_EQ) take(P_MOD_EQ);
        else if (c == CH_GT) take(P_PCT_GT);
        else miss = 1'b1;
      end
      M_PCTC: begin
        if (c == CH_PCT) lex_mode = M_PCTCP;
        else begin
          put_tok(KIND_PUNCT, P_PCT_COLON);
          reopen(c);
        end
      end
      M_PCTCP: begin
        if (c == CH_COLON) take(P_DPASTE);
        else begin
          put_tok(KIND_ERR, 8'h00);
          reopen(c);
        end
      end
      M_HASH:  if (c == CH_HASH) take(P_HASHHASH); else miss = 1'b1;
      M_CARET: if (c == CH_EQ) take(P_XOR_EQ); else miss = 1'b1;
      default: reopen(c);
    endcase
    // single-byte prefix broken: flush its lead byte, then rescan
    if (miss) begin
      put_tok(KIND_BYTE, lex_lead);
      reopen(c);
    end
  endfunction

  function automatic void flush_mode();
    case (lex_mode)
      M_LTLT: put_tok(KIND_PUNCT, P_SHL);
      M_GTGT: put_tok(KIND_PUNCT, P_SHR);
      M_PCTC: put_tok(KIND_PUNCT, P_PCT_COLON);
      M_DOTDOT, M_PCTCP, M_BLOCK, M_BSTAR: put_tok(KIND_ERR, 8'h00);
      M_IDLE, M_LINE: ;
      default: put_tok(KIND_BYTE, lex_lead);
    endcase
    put_tok(KIND_END, 8'h00);
    lex_mode = M_IDLE;
  endfunction

  function automatic void tokenize_step(input logic [7:0] c, input logic fin);
    step_toks.delete();
    if (fin) flush_mode();
    else advance_mode(c);
    if (step_toks.size() != 0) step_toks[step_toks.size()-1].last = 1'b1;
  endfunction

  // ---------------- checking ----------------

  always @(posedge clk) begin : watch
    tok_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_tokens.size() == 0) begin
          flag_mismatch($sformatf("unexpected token kind %0d code %0d", out_kind, out_code));
        end else begin
          want = pending_tokens.pop_front();
          if (out_kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
          if (out_code !== want.code)
            flag_mismatch($sformatf("code %0d, want %0d", out_code, want.code));
          if (out_last !== want.last)
            flag_mismatch($sformatf("last %0b, want %0b", out_last, want.last));
        end
      end
      if (in_valid && in_ready) begin
        tokenize_step(in_byte_req, in_at_end);
        if (cur_n_fixed >= 0) begin
          if (cur_n_fixed >= 1) pending_tokens.push_back(cur_t0);
          if (cur_n_fixed >= 2) pending_tokens.push_back(cur_t1);
        end else begin
          foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 37);
  end

  // ---------------- stimulus ----------------

  task automatic add_row(input logic [7:0] ch, input logic fin, input int n,
                         input logic [1:0] k0, input logic [7:0] c0,
                         input logic [1:0] k1, input logic [7:0] c1);
    req_t r;
    r.ch = ch;
    r.fin = fin;
    r.hold = 1'b0;
    r.n_fixed = n;
    r.t0.kind = k0;
    r.t0.code = c0;
    r.t0.last = (n == 1);
    r.t1.kind = k1;
    r.t1.code = c1;
    r.t1.last = 1'b1;
    stim_q.push_back(r);
  endtask

  task automatic plan_byte(input logic [7:0] ch, input logic fin);
    add_row(ch, fin, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
  endtask

  task automatic plan_text(input string s);
    for (int i = 0; i < s.len(); i++) plan_byte(s[i], 1'b0);
  endtask

  task automatic plan_punct(input int k);
    int idx;
    idx = 0;
    for (int i = 0; i < punct_text.len(); i++) begin
      if (punct_text[i] == " ") idx++;
      else if (idx == k) plan_byte(punct_text[i], 1'b0);
    end
  endtask

  function automatic logic [7:0] space_byte();
    case ($urandom_range(5))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_NL;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  // comment body biased toward '*' and '/' so the close is hit and missed
  task automatic plan_body(input int len, input bit line);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0: b = CH_STAR;
        1: b = CH_SLASH;
        default: b = any_byte();
      endcase
      if (line && b == CH_NL) b = CH_SP;
      plan_byte(b, 1'b0);
    end
  endtask

  task automatic plan_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      plan_punct($urandom_range(27));
    end else if (pick < 40) begin
      plan_byte(any_byte(), 1'b0);
    end else if (pick < 47) begin
      plan_byte(space_byte(), 1'b0);
    end else if (pick < 55) begin
      plan_text("/*");
      plan_body($urandom_range(6), 0);
      plan_text("*/");
    end else if (pick < 61) begin
      plan_text("//");
      plan_body($urandom_range(5), 1);
      plan_byte(CH_NL, 1'b0);
    end else if (pick < 71) begin
      plan_byte(lead_text[$urandom_range(lead_text.len()-1)], 1'b0);
      plan_byte(any_byte(), 1'b0);
    end else if (pick < 76) begin
      if ($urandom_range(1)) plan_text(".."); else plan_text("%:%");
      plan_byte(any_byte(), 1'b0);
    end else if (pick < 81) begin
      case ($urandom_range(2))
        0: plan_text("%:");
        1: plan_text("<<");
        default: plan_text(">>");
      endcase
      plan_byte(any_byte(), 1'b0);
    end else if (pick < 91) begin
      plan_byte(any_byte(), 1'b1);
    end else begin
      // a prefix or an open comment cut short by the end marker
      case ($urandom_range(5))
        0: plan_text("/*");
        1: plan_text("/**");
        2: plan_text("//");
        3: plan_text("..");
        4: plan_text("%:%");
        default: plan_byte(lead_text[$urandom_range(lead_text.len()-1)], 1'b0);
      endcase
      plan_byte(any_byte(), 1'b1);
    end
    if ($urandom_range(99) < 2) stim_q[stim_q.size()-1].hold = 1'b1;
  endtask

  task automatic send_req(input req_t r);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_byte_req <= r.ch;
    in_at_end   <= r.fin;
    cur_n_fixed <= r.n_fixed;
    cur_t0      <= r.t0;
    cur_t1      <= r.t1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(negedge clk);
  endtask

  initial begin
    int n_directed;
    int quiet_lo;
    int quiet_hi;

    // reset state, byte extremes, both dangling errors, unclosed comment,
    // pending shift at end, lone dot, ellipsis, line comment, end from idle
    add_row(8'h00,    1'b0,  1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(8'hFF,    1'b0,  1, KIND_BYTE, 8'hFF, KIND_BYTE, 8'h00);
    add_row(CH_DOT,   1'b0,  0, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(CH_DOT,   1'b0,  0, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(8'h61,    1'b0,  2, KIND_ERR,  8'h00, KIND_BYTE, 8'h61);
    add_row(CH_PCT,   1'b0,  0, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(CH_COLON, 1'b0,  0, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(CH_PCT,   1'b0,  0, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(8'h3B,    1'b0,  2, KIND_ERR,  8'h00, KIND_BYTE, 8'h3B);
    add_row(CH_SLASH, 1'b0,  0, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(CH_STAR,  1'b0,  0, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(CH_SLASH, 1'b0,  0, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(8'hFF,    1'b1,  2, KIND_ERR,  8'h00, KIND_END,  8'h00);
    add_row(CH_LT,    1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(CH_LT,    1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(8'h00,    1'b1,  2, KIND_PUNCT, P_SHL, KIND_END, 8'h00);
    add_row(CH_DOT,   1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(8'h78,    1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(CH_DOT,   1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(CH_DOT,   1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(CH_DOT,   1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(CH_SLASH, 1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(CH_SLASH, 1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(CH_NL,    1'b0, -1, KIND_BYTE, 8'h00, KIND_BYTE, 8'h00);
    add_row(8'h00,    1'b1,  1, KIND_END,  8'h00, KIND_BYTE, 8'h00);
    n_directed = stim_q.size();

    while (stim_q.size() < 470) plan_random();
    stim_q[n_directed].hold = 1'b1;
    quiet_lo = n_directed + 150;
    quiet_hi = n_directed + 260;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_q[i]) begin
      quiet = (i >= quiet_lo) && (i < quiet_hi);
      if (stim_q[i].hold) wait_drained();
      send_req(stim_q[i]);
    end
    quiet = 0;
    wait_drained();
    repeat (20) @(negedge clk);

    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cpt_pkg.sv
rtl/core/cpt_front.sv
rtl/core/cpt_queue.sv
rtl/core/cpt_back.sv
rtl/core/c_punctuator_tokenizer.sv
test/c_punctuator_tokenizer_tb.sv
